// ----- design/cfle_pkg.sv -----
// Package for the chunk framing link endpoint: sizes, request and status codes,
// and the types passed between the front and back parts. No dependencies.
package cfle_pkg;

  localparam int unsigned TxStoreDepth = 4096;
  localparam int unsigned TxPacketSlots = 8;
  localparam int unsigned StoreAw = $clog2(TxStoreDepth);
  localparam int unsigned CountW = StoreAw + 1;
  localparam int unsigned SlotAw = (TxPacketSlots > 1) ? $clog2(TxPacketSlots) : 1;
  localparam int unsigned SlotCw = $clog2(TxPacketSlots + 1);
  localparam logic [7:0] CapDefault = 8'd255;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REQ_RX   = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_SEND = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_NOTHING = 3'd0,
    ST_RX_DATA = 3'd1,
    ST_RX_END  = 3'd2,
    ST_TX_BYTE = 3'd3,
    ST_LOAD_OK = 3'd4,
    ST_LOAD_NO = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_CHUNK_CAP    = 2'd0,
    REG_BLOCK_ENABLE = 2'd1
  } reg_e;

  // Item handed from the front to the back part.
  typedef struct packed {
    req_e       req;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       tx_is_header;
    logic       ack_pending;
    logic       tx_blocked;
  } result_t;

endpackage

// ----- design/cfle_if.sv -----
// Valid/ready channel interfaces for the endpoint's input and result items.
// Depends on cfle_pkg.
interface cfle_in_if;
  import cfle_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       load_last;
  modport source(output valid, req_type, data_byte, load_last, input ready);
  modport sink(input valid, req_type, data_byte, load_last, output ready);
endinterface

interface cfle_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       tx_is_header;
  logic       ack_pending;
  logic       tx_blocked;
  modport source(output valid, status, out_byte, tx_is_header, ack_pending, tx_blocked,
                 input ready);
  modport sink(input valid, status, out_byte, tx_is_header, ack_pending, tx_blocked,
               output ready);
endinterface

// ----- design/cfle_front.sv -----
// Front part: accepts input items, classifies the request and queues them.
// Depends on cfle_pkg and cfle_if.
module cfle_front import cfle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfle_in_if.sink    in_if,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);
  localparam int unsigned Aw = $clog2(QueueDepth);

  cmd_t fifo_q [QueueDepth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;
  logic push, pop;
  cmd_t cmd_in;

  // The request field maps one to one onto the request codes; code 3 is the idle request.
  always_comb begin
    cmd_in.data = in_if.data_byte;
    cmd_in.last = in_if.load_last;
    cmd_in.req = req_e'(in_if.req_type);
  end

  assign in_if.ready = (cnt_q != (Aw+1)'(QueueDepth));
  assign push = in_if.valid && in_if.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop = cmd_valid_o && cmd_ready_i;
  assign cmd_o = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (Aw+1)'(QueueDepth))
    else $error("front queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !cmd_valid_o) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

// ----- design/cfle_back.sv -----
// Back part: receive parser, transmit packet queue with byte store, chunker
// and the registered result stage. Depends on cfle_pkg.
module cfle_back import cfle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] chunk_cap_i,
  input  logic       block_enable_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_ready_o,
  cfle_out_if.source out_if
);
  // Memory read is registered, so a send of a data byte takes the item into a
  // holding stage; the store is read as the item is taken, and the result waits there for the output register.
  logic [7:0] store_mem [TxStoreDepth];
  logic [CountW-1:0] plen_mem [TxPacketSlots];

  logic [7:0]        rx_rem_q;
  logic              rx_open_q, ack_q, blk_q;
  logic [StoreAw-1:0] head_q;
  logic [CountW-1:0] used_q, load_len_q, offset_q;
  logic [SlotAw-1:0] shead_q;
  logic [SlotCw-1:0] scount_q;
  logic [7:0]        size_q;
  logic [8:0]        sent_q;

  logic              rv_q;   // result register
  result_t           res_q;
  logic              mem_pend_q;  // result waits for a store read
  result_t           pend_res_q;
  logic [7:0]        rd_data_q;
  result_t           pend_out;

  logic [7:0] cap;
  logic [CountW-1:0] plen;
  logic out_free, take;
  result_t res_d;
  logic use_mem;

  assign cap = (chunk_cap_i == 8'd0) ? CapDefault : chunk_cap_i;
  assign plen = plen_mem[shead_q];
  assign out_free = !rv_q || out_if.ready;
  assign cmd_ready_o = out_free && !mem_pend_q;
  assign take = cmd_valid_i && cmd_ready_o;

  // Next-state values of the control state.
  logic [7:0] rx_rem_d; logic rx_open_d, ack_d, blk_d;
  logic [StoreAw-1:0] head_d; logic [CountW-1:0] used_d, load_len_d, offset_d;
  logic [SlotAw-1:0] shead_d; logic [SlotCw-1:0] scount_d;
  logic [7:0] size_d; logic [8:0] sent_d;
  logic wr_en, len_wr; logic [StoreAw-1:0] wr_addr, rd_addr; logic [SlotAw-1:0] len_addr;

  always_comb begin
    logic [CountW-1:0] avail;
    logic [8:0] sent_n;
    logic [7:0] size_n;
    logic [CountW-1:0] off_n;
    rx_rem_d = rx_rem_q; rx_open_d = rx_open_q; ack_d = ack_q; blk_d = blk_q;
    head_d = head_q; used_d = used_q; load_len_d = load_len_q; offset_d = offset_q;
    shead_d = shead_q; scount_d = scount_q; size_d = size_q; sent_d = sent_q;
    wr_en = 1'b0; len_wr = 1'b0; use_mem = 1'b0;
    wr_addr = head_q + used_q[StoreAw-1:0];
    len_addr = SlotAw'((32'(shead_q) + 32'(scount_q)) % TxPacketSlots);
    rd_addr = head_q + offset_q[StoreAw-1:0] + StoreAw'(sent_q) - 1'b1;
    avail = '0; sent_n = '0; size_n = '0; off_n = '0;
    res_d = '0;
    unique case (cmd_i.req)
      REQ_RX: begin
        if (rx_rem_q == 8'd0) begin
          blk_d = 1'b0;
          if (cmd_i.data != 8'd0) begin
            rx_rem_d = cmd_i.data; rx_open_d = 1'b1; ack_d = 1'b1;
          end else if (rx_open_q) begin
            rx_open_d = 1'b0; ack_d = 1'b1; res_d.status = ST_RX_END;
          end
        end else begin
          rx_rem_d = rx_rem_q - 1'b1;
          res_d.status = ST_RX_DATA; res_d.out_byte = cmd_i.data;
        end
      end
      REQ_LOAD: begin
        if (used_q >= CountW'(TxStoreDepth) || scount_q >= SlotCw'(TxPacketSlots)) begin
          res_d.status = ST_LOAD_NO;
        end else begin
          wr_en = 1'b1;
          used_d = used_q + 1'b1;
          load_len_d = load_len_q + 1'b1;
          if (cmd_i.last) begin
            len_wr = 1'b1; scount_d = scount_q + 1'b1; load_len_d = '0;
          end
          res_d.status = ST_LOAD_OK;
        end
      end
      REQ_SEND: begin
        if (blk_q) begin
          res_d.status = ST_NOTHING;
        end else if (scount_q == '0) begin
          if (ack_q) begin
            ack_d = 1'b0; res_d.status = ST_TX_BYTE; res_d.tx_is_header = 1'b1;
          end
        end else begin
          res_d.status = ST_TX_BYTE;
          size_n = size_q;
          if (sent_q == 9'd0) begin
            avail = (plen > offset_q) ? plen - offset_q : '0;
            if (avail > CountW'(cap)) avail = CountW'(cap);
            size_n = avail[7:0];
            sent_n = 9'd1;
            res_d.out_byte = avail[7:0]; res_d.tx_is_header = 1'b1;
          end else begin
            use_mem = 1'b1;
            sent_n = sent_q + 1'b1;
          end
          ack_d = 1'b0;
          size_d = size_n; sent_d = sent_n; off_n = offset_q;
          if (sent_n > {1'b0, size_n}) begin
            off_n = offset_q + CountW'(size_n);
            if (size_n == cap) blk_d = block_enable_i;
            size_d = '0; sent_d = '0;
            if (size_n == 8'd0 && off_n >= plen) begin
              head_d = head_q + plen[StoreAw-1:0];
              used_d = (used_q >= plen) ? used_q - plen : '0;
              shead_d = SlotAw'((32'(shead_q) + 1) % TxPacketSlots);
              scount_d = scount_q - 1'b1;
              off_n = '0;
              blk_d = block_enable_i;
            end
          end
          offset_d = off_n;
        end
      end
      default: res_d.status = ST_NOTHING;
    endcase
    res_d.ack_pending = ack_d;
    res_d.tx_blocked = blk_d;
  end

  always_comb begin
    pend_out = pend_res_q;
    pend_out.out_byte = rd_data_q;
  end

  always_ff @(posedge clk_i) begin
    if (take && wr_en) store_mem[wr_addr] <= cmd_i.data;
    if (take && len_wr) plen_mem[len_addr] <= load_len_q + 1'b1;
    if (take) rd_data_q <= store_mem[rd_addr];
    if (take) pend_res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_rem_q <= '0; rx_open_q <= 1'b0; ack_q <= 1'b0; blk_q <= 1'b0;
      head_q <= '0; used_q <= '0; load_len_q <= '0; offset_q <= '0;
      shead_q <= '0; scount_q <= '0; size_q <= '0; sent_q <= '0;
      rv_q <= 1'b0; res_q <= '0; mem_pend_q <= 1'b0;
    end else begin
      if (take) begin
        rx_rem_q <= rx_rem_d; rx_open_q <= rx_open_d; ack_q <= ack_d; blk_q <= blk_d;
        head_q <= head_d; used_q <= used_d; load_len_q <= load_len_d;
        offset_q <= offset_d; shead_q <= shead_d; scount_q <= scount_d;
        size_q <= size_d; sent_q <= sent_d;
      end
      if (mem_pend_q) begin
        if (out_free) begin
          rv_q <= 1'b1;
          res_q <= pend_out;
          mem_pend_q <= 1'b0;
        end
      end else if (take && !use_mem) begin
        rv_q <= 1'b1; res_q <= res_d;
      end else if (take) begin
        mem_pend_q <= 1'b1;
        if (out_if.ready) rv_q <= 1'b0;
      end else if (out_if.ready) begin
        rv_q <= 1'b0;
      end
    end
  end

  // The store byte is captured when its item is taken, so it stays valid while the
  // result waits for the output register.
  assign out_if.valid = rv_q;
  assign out_if.status = res_q.status;
  assign out_if.out_byte = res_q.out_byte;
  assign out_if.tx_is_header = res_q.tx_is_header;
  assign out_if.ack_pending = res_q.ack_pending;
  assign out_if.tx_blocked = res_q.tx_blocked;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_pend_q |-> !cmd_ready_o) else $error("item taken during store read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scount_q <= SlotCw'(TxPacketSlots)) else $error("slot count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CountW'(TxStoreDepth)) else $error("store count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q && !out_if.ready) |=> rv_q && $stable(res_q)) else $error("result lost");
endmodule

// ----- design/cfle_regs.sv -----
// APB-style configuration registers: chunk cap and block enable.
// Depends on cfle_pkg.
module cfle_regs import cfle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  chunk_cap_o,
  output logic        block_enable_o
);
  logic [7:0] cap_q;
  logic       ben_q;
  logic       wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapDefault;
      ben_q <= 1'b1;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (paddr[2] == 1'b0) cap_q <= pwdata[7:0];
      else ben_q <= pwdata[0];
    end
  end

  always_comb begin
    unique case (reg_e'({1'b0, paddr[2]}))
      REG_CHUNK_CAP:    prdata = {24'd0, cap_q};
      REG_BLOCK_ENABLE: prdata = {31'd0, ben_q};
      default:          prdata = '0;
    endcase
  end

  assign chunk_cap_o = cap_q;
  assign block_enable_o = ben_q;
endmodule

// ----- design/chunk_framing_link_endpoint.sv -----
// Top level of the chunk framing link endpoint: front queue, back part and
// configuration registers. Depends on cfle_pkg, cfle_if and the submodules.
//
// Every item is answered by exactly one result, in order. Receive, load, header
// sends and idle requests go from the back part straight into the result register,
// so they can follow back to back; a send of a packet data byte passes a holding
// stage first, since the byte store's read is registered. A two-entry queue
// separates acceptance from the back part, and the result register is refilled in
// the same cycle its previous result is taken; while a result waits, the back
// part holds off.
module chunk_framing_link_endpoint import cfle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfle_in_if.sink     in_if,
  cfle_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic       cmd_valid, cmd_ready;
  cmd_t       cmd;
  logic [7:0] chunk_cap;
  logic       block_enable;

  cfle_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .chunk_cap_o(chunk_cap), .block_enable_o(block_enable)
  );

  cfle_front u_front (
    .clk_i, .rst_ni, .in_if,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  cfle_back u_back (
    .clk_i, .rst_ni, .chunk_cap_i(chunk_cap), .block_enable_i(block_enable),
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready), .out_if
  );
endmodule
